// ===== design/energy_speech_gate_macros.svh =====
// Assertion macros for the energy speech gate checker.
// Each macro expects signals named clk and arst_n in the scope where it is used.
`ifndef ENERGY_SPEECH_GATE_MACROS_SVH
`define ENERGY_SPEECH_GATE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ESG_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("energy_speech_gate: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ESG_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("energy_speech_gate: next-cycle check failed");

`endif

// ===== design/esg_pkg.sv =====
// Shared types and constants for the energy speech gate.
// Used by every module of the block; depends on nothing else.
package esg_pkg;

	localparam int MAX_CHUNK_SAMPLES = 640;

	localparam int SAMPLE_W = 16;
	localparam int MAG_W    = SAMPLE_W + 1;
	localparam int COUNT_W  = $clog2(MAX_CHUNK_SAMPLES + 1);
	localparam int SUM_W    = $clog2(MAX_CHUNK_SAMPLES * 32768 + 1);
	localparam int THR_W    = 16;
	localparam int LIMIT_W  = THR_W + 1;
	localparam int PROD_W   = LIMIT_W + COUNT_W;
	localparam int RUN_W    = 8;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [THR_W-1:0] RESET_THRESHOLD = 16'd600;
	localparam logic [RUN_W-1:0] RESET_MIN_LOUD  = 8'd8;
	localparam logic [RUN_W-1:0] RUN_MAX         = 8'd255;

	localparam logic [COUNT_W-1:0] COUNT_LIMIT = COUNT_W'(MAX_CHUNK_SAMPLES);

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_GATE_THRESHOLD  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOUD_CHUNKS = 2'd1;

	// Request kinds.
	localparam logic REQ_SAMPLE    = 1'b0;
	localparam logic REQ_UTTERANCE = 1'b1;

	typedef struct packed {
		logic                       req_type;
		logic signed [SAMPLE_W-1:0] sample;
		logic                       last_in_chunk;
	} req_t;

	typedef struct packed {
		logic             heard_voice;
		logic             chunk_done;
		logic             chunk_loud;
		logic [RUN_W-1:0] loud_run;
		logic             chunk_too_long;
	} res_t;

	typedef struct packed {
		logic [THR_W-1:0] gate_threshold;
		logic [RUN_W-1:0] min_loud_chunks;
	} cfg_t;

endpackage

// ===== design/esg_in_reg.sv =====
// Input register of the energy speech gate: captures one request word per cycle unless stalled.
// Depends on esg_pkg for the request type.
module esg_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  esg_pkg::req_t req_data,
	input  logic          advance,
	output logic          valid_s1,
	output esg_pkg::req_t data_s1
);

	logic accept;

	// The held word leaves whenever the result register can take it.
	assign req_stall = valid_s1 && !advance;
	assign accept    = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			data_s1 <= req_data;
		end
	end

endmodule

// ===== design/esg_eval.sv =====
// Chunk accumulator and gate decision of the energy speech gate.
// Holds the chunk sum, count and loud-run state; depends on esg_pkg.
module esg_eval (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          fire,
	input  esg_pkg::req_t item,
	input  esg_pkg::cfg_t cfg,
	output esg_pkg::res_t result
);

	logic [esg_pkg::SUM_W-1:0]   sum_q;
	logic [esg_pkg::COUNT_W-1:0] count_q;
	logic                        ovf_q;
	logic [esg_pkg::RUN_W-1:0]   run_q;
	logic                        latched_q;

	logic [esg_pkg::MAG_W-1:0]   mag;
	logic                        can_add;
	logic [esg_pkg::SUM_W-1:0]   sum_nx;
	logic [esg_pkg::COUNT_W-1:0] count_nx;
	logic                        ovf_nx;
	logic [esg_pkg::LIMIT_W-1:0] limit;
	logic [esg_pkg::PROD_W-1:0]  need;
	logic                        loud;
	logic [esg_pkg::RUN_W-1:0]   run_inc;
	logic [esg_pkg::RUN_W-1:0]   run_nx;
	logic                        latched_nx;
	logic                        clear_chunk;

	always_comb begin
		// Two's complement magnitude; the most negative sample gives 32768.
		if (item.sample[esg_pkg::SAMPLE_W-1]) begin
			mag = esg_pkg::MAG_W'(0) - {1'b1, item.sample};
		end else begin
			mag = {1'b0, item.sample};
		end

		can_add  = count_q < esg_pkg::COUNT_LIMIT;
		sum_nx   = can_add ? sum_q + esg_pkg::SUM_W'(mag) : sum_q;
		count_nx = can_add ? count_q + esg_pkg::COUNT_W'(1) : count_q;
		ovf_nx   = ovf_q || !can_add;

		// Loud when floor(sum / count) > threshold, i.e. sum >= (threshold + 1) * count.
		limit = esg_pkg::LIMIT_W'(cfg.gate_threshold) + esg_pkg::LIMIT_W'(1);
		need  = esg_pkg::PROD_W'(limit) * esg_pkg::PROD_W'(count_nx);
		loud  = esg_pkg::PROD_W'(sum_nx) >= need;

		run_inc = (run_q == esg_pkg::RUN_MAX) ? run_q : run_q + esg_pkg::RUN_W'(1);

		run_nx      = run_q;
		latched_nx  = latched_q;
		clear_chunk = 1'b0;
		result      = '0;

		if (item.req_type == esg_pkg::REQ_UTTERANCE) begin
			run_nx      = '0;
			latched_nx  = 1'b0;
			clear_chunk = 1'b1;
		end else if (!latched_q) begin
			if (item.last_in_chunk) begin
				clear_chunk           = 1'b1;
				result.chunk_done     = 1'b1;
				result.chunk_loud     = loud;
				result.chunk_too_long = ovf_nx;
				if (loud) begin
					run_nx = run_inc;
					if (run_inc >= cfg.min_loud_chunks) begin
						latched_nx = 1'b1;
					end
				end else begin
					run_nx = '0;
				end
			end
		end

		result.heard_voice = latched_nx;
		result.loud_run    = run_nx;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q     <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			run_q     <= '0;
			latched_q <= 1'b0;
		end else if (fire) begin
			run_q     <= run_nx;
			latched_q <= latched_nx;
			if (clear_chunk) begin
				sum_q   <= '0;
				count_q <= '0;
				ovf_q   <= 1'b0;
			end else if (!latched_q) begin
				sum_q   <= sum_nx;
				count_q <= count_nx;
				ovf_q   <= ovf_nx;
			end
		end
	end

endmodule

// ===== design/esg_out_reg.sv =====
// Result register of the energy speech gate, holding one word toward the receiver.
// Depends on esg_pkg for the result type.
module esg_out_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          load,
	input  esg_pkg::res_t result,
	output logic          advance,
	output logic          res_valid,
	input  logic          res_stall,
	output esg_pkg::res_t res_data
);

	logic valid_q;
	esg_pkg::res_t data_q;

	assign advance   = !valid_q || !res_stall;
	assign res_valid = valid_q;
	assign res_data  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && load) begin
			data_q <= result;
		end
	end

endmodule

// ===== design/energy_speech_gate.sv =====
// Energy speech gate: per-chunk mean absolute level test with a latched voice flag.
// A request word is either a 16-bit sample or a new-utterance marker; each word
// gives exactly one result word. Samples are summed as absolute values until one
// arrives with last_in_chunk set; that word closes the chunk and reports whether
// its mean level exceeded gate_threshold. min_loud_chunks loud chunks in a row
// set heard_voice, after which samples are ignored until a new-utterance word.
// Channels: req_valid/req_stall/req_data in, res_valid/res_stall/res_data out,
// cfg_valid/cfg_ready/cfg_index/cfg_data for register writes (always ready).
// A word waits in the input register until the result register takes its result.
// Throughput: one word per cycle; the input register and the result register
// form a two-stage pipeline whose single evaluation stage updates the state.
// When the receiver stalls, the result word holds, the input register fills,
// and req_stall rises once both are occupied.
// Reset clears the chunk sum and count, the loud run and the voice flag, and
// loads gate_threshold = 600 and min_loud_chunks = 8; no clearing pass follows.
// Writes to register indexes beyond the two defined ones are ignored.
module energy_speech_gate (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                req_valid,
	output logic                                req_stall,
	input  esg_pkg::req_t                       req_data,
	output logic                                res_valid,
	input  logic                                res_stall,
	output esg_pkg::res_t                       res_data,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [esg_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [esg_pkg::CFG_DATA_W-1:0]      cfg_data
);

	esg_pkg::cfg_t cfg_q;
	logic          advance;
	logic          valid_s1;
	esg_pkg::req_t data_s1;
	logic          fire;
	esg_pkg::res_t result;

	assign cfg_ready = 1'b1;
	assign fire      = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gate_threshold  <= esg_pkg::RESET_THRESHOLD;
			cfg_q.min_loud_chunks <= esg_pkg::RESET_MIN_LOUD;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				esg_pkg::CFG_GATE_THRESHOLD: begin
					cfg_q.gate_threshold <= esg_pkg::THR_W'(cfg_data);
				end
				esg_pkg::CFG_MIN_LOUD_CHUNKS: begin
					cfg_q.min_loud_chunks <= cfg_data[esg_pkg::RUN_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	esg_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req_data  (req_data),
		.advance   (advance),
		.valid_s1  (valid_s1),
		.data_s1   (data_s1)
	);

	esg_eval u_eval (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (data_s1),
		.cfg    (cfg_q),
		.result (result)
	);

	esg_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (fire),
		.result    (result),
		.advance   (advance),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res_data  (res_data)
	);

endmodule

// ===== design/esg_checker.sv =====
// Port-level checker for the energy speech gate, bound to the top level.
// Depends on esg_pkg and the assertion macros in energy_speech_gate_macros.svh.
`include "energy_speech_gate_macros.svh"

module esg_checker (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          res_valid,
	input  logic          res_stall,
	input  esg_pkg::res_t res_data
);

	// A chunk can only be loud or too long when it was closed by this word.
	`ESG_ASSERT_NOW(a_loud_needs_done, res_valid && res_data.chunk_loud, res_data.chunk_done)
	`ESG_ASSERT_NOW(a_long_needs_done, res_valid && res_data.chunk_too_long, res_data.chunk_done)

	// A quiet chunk breaks the run, and the gate could not have been latched.
	`ESG_ASSERT_NOW(a_quiet_clears_run,
		res_valid && res_data.chunk_done && !res_data.chunk_loud,
		res_data.loud_run == '0 && !res_data.heard_voice)

	// A stalled result stays offered and unchanged.
	`ESG_ASSERT_NEXT(a_stall_holds, res_valid && res_stall,
		res_valid && $stable(res_data))

endmodule

bind energy_speech_gate esg_checker u_esg_checker (.*);

// ===== verif/tb_top.sv =====
// Self-checking testbench for energy_speech_gate: drives sample and new-utterance
// words, predicts every result word in SystemVerilog, and compares in order.
// Depends on esg_pkg and the energy_speech_gate RTL only.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import esg_pkg::*;

	localparam int HOLD_CYCLES = 60;
	localparam int STALL_LIMIT = 3000;
	localparam int MAX_REPORTS = 10;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_INDEX = 2'd3;

	typedef enum {LVL_LOUD, LVL_QUIET, LVL_MIXED, LVL_ANY} level_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	req_t req_data = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	res_t res_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	req_t words_q[$];
	res_t verdicts_q[$];
	res_t want;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int hold_left = 0;
	logic hold_kick = 1'b0;
	logic hold_seen = 1'b0;

	// Shadow of the gate's registers and chunk state.
	logic [THR_W-1:0] thr_cfg = RESET_THRESHOLD;
	logic [RUN_W-1:0] min_cfg = RESET_MIN_LOUD;
	logic [SUM_W-1:0] open_sum = '0;
	logic [COUNT_W-1:0] open_count = '0;
	logic open_over = 1'b0;
	logic [RUN_W-1:0] run_len = '0;
	logic voice = 1'b0;

	energy_speech_gate DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data(req_data),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.res_data(res_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Advances the shadow state by one accepted word and returns its result word.
	function automatic res_t evaluate_word(req_t w);
		res_t r;
		logic [MAG_W-1:0] mag;
		r = '0;
		if (w.req_type == REQ_UTTERANCE) begin
			open_sum = '0;
			open_count = '0;
			open_over = 1'b0;
			run_len = '0;
			voice = 1'b0;
		end else if (!voice) begin
			mag = w.sample[SAMPLE_W-1] ? MAG_W'(17'h10000 - {1'b0, w.sample})
				: MAG_W'(w.sample);
			if (open_count < COUNT_LIMIT) begin
				open_sum = open_sum + SUM_W'(mag);
				open_count = open_count + 1'b1;
			end else begin
				open_over = 1'b1;
			end
			if (w.last_in_chunk) begin
				r.chunk_done = 1'b1;
				r.chunk_too_long = open_over;
				r.chunk_loud = longint'(open_sum) >=
					(longint'(thr_cfg) + 1) * longint'(open_count);
				if (r.chunk_loud) begin
					if (run_len != RUN_MAX)
						run_len = run_len + 1'b1;
					if (run_len >= min_cfg)
						voice = 1'b1;
				end else begin
					run_len = '0;
				end
				open_sum = '0;
				open_count = '0;
				open_over = 1'b0;
			end
		end
		r.heard_voice = voice;
		r.loud_run = run_len;
		return r;
	endfunction

	// Request side: one word per handshake, held while stalled.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req_data <= '0;
		end else begin
			if (req_valid && !req_stall)
				verdicts_q.push_back(evaluate_word(req_data));
			if (!req_valid || !req_stall) begin
				if (words_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req_data <= words_q.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// Result side stall, with an occasional long hold-off to back the block up.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_stall <= 1'b0;
			hold_left <= 0;
			hold_seen <= 1'b0;
		end else if (hold_kick != hold_seen) begin
			hold_seen <= hold_kick;
			hold_left <= HOLD_CYCLES;
			res_stall <= 1'b1;
		end else if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else begin
			res_stall <= $urandom_range(99) < recv_stall_pct;
		end
	end

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (verdicts_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS)
					$display("result word with none expected: ",
						"hv=%0d done=%0d loud=%0d run=%0d long=%0d",
						res_data.heard_voice, res_data.chunk_done, res_data.chunk_loud,
						res_data.loud_run, res_data.chunk_too_long);
			end else begin
				want = verdicts_q.pop_front();
				if (res_data.heard_voice !== want.heard_voice ||
						res_data.chunk_done !== want.chunk_done ||
						res_data.chunk_loud !== want.chunk_loud ||
						res_data.loud_run !== want.loud_run ||
						res_data.chunk_too_long !== want.chunk_too_long) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS)
						$display("%0t: expected hv=%0d done=%0d loud=%0d run=%0d long=%0d,",
							$realtime, want.heard_voice, want.chunk_done, want.chunk_loud,
							want.loud_run, want.chunk_too_long,
							" got hv=%0d done=%0d loud=%0d run=%0d long=%0d",
							res_data.heard_voice, res_data.chunk_done,
							res_data.chunk_loud, res_data.loud_run,
							res_data.chunk_too_long);
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && !req_stall) || (res_valid && !res_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	task automatic push_word(input logic kind, input logic [SAMPLE_W-1:0] s,
			input logic last);
		req_t w;
		w.req_type = kind;
		w.sample = s;
		w.last_in_chunk = last;
		words_q.push_back(w);
	endtask

	// Picks a level just above or at/below the threshold so chunks land either side.
	function automatic int pick_mag(level_t lv);
		int thr;
		int lo;
		int hi;
		thr = int'(thr_cfg);
		lo = 0;
		hi = 32768;
		if (lv == LVL_MIXED)
			lv = ($urandom_range(1) != 0) ? LVL_LOUD : LVL_QUIET;
		if (lv == LVL_LOUD && thr < 32768) begin
			lo = thr + 1;
			hi = (thr + 6 < 32768) ? thr + 6 : 32768;
		end else if (lv == LVL_QUIET) begin
			lo = (thr > 5) ? thr - 5 : 0;
			hi = (thr < 32768) ? thr : 32768;
		end
		return $urandom_range(hi, lo);
	endfunction

	function automatic logic [SAMPLE_W-1:0] to_sample(int mag);
		if (mag == 32768 || (mag != 0 && $urandom_range(1) != 0))
			return SAMPLE_W'(-mag);
		return SAMPLE_W'(mag);
	endfunction

	task automatic push_chunk(input int len, input level_t lv);
		for (int i = 0; i < len; i++)
			push_word(REQ_SAMPLE, to_sample(pick_mag(lv)), i == len - 1);
	endtask

	// Mostly whole utterances of chunks with random content, some raw noise words.
	task automatic fill_random(input int n_words);
		int start;
		int nch;
		int r;
		level_t lv;
		start = words_q.size();
		while (words_q.size() - start < n_words) begin
			if ($urandom_range(99) < 10) begin
				repeat ($urandom_range(4, 1))
					push_word(1'($urandom_range(1)), SAMPLE_W'($urandom),
						1'($urandom_range(1)));
			end else begin
				push_word(REQ_UTTERANCE, SAMPLE_W'($urandom), 1'($urandom_range(1)));
				nch = (int'(min_cfg) + 2 < 10) ? int'(min_cfg) + 2 : 10;
				repeat ($urandom_range(nch, 1)) begin
					r = $urandom_range(99);
					lv = (r < 70) ? LVL_LOUD : (r < 85) ? LVL_QUIET
						: (r < 95) ? LVL_MIXED : LVL_ANY;
					push_chunk(($urandom_range(49) == 0) ? $urandom_range(40, 9)
						: $urandom_range(6, 1), lv);
				end
				// Trailing samples, often swallowed by a latched gate.
				repeat ($urandom_range(3, 0))
					push_word(REQ_SAMPLE, to_sample(pick_mag(LVL_ANY)),
						1'($urandom_range(1)));
			end
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == CFG_GATE_THRESHOLD)
			thr_cfg = data;
		else if (idx == CFG_MIN_LOUD_CHUNKS)
			min_cfg = data[RUN_W-1:0];
	endtask

	// Every word yields one result, so an empty expectation queue means idle.
	task automatic settle();
		do @(negedge clk);
		while (words_q.size() != 0 || req_valid || verdicts_q.size() != 0);
	endtask

	task automatic start_phase(input int idle_pct, input int stall_pct,
			input logic [THR_W-1:0] thr, input logic [RUN_W-1:0] min_run);
		settle();
		send_idle_pct = idle_pct;
		recv_stall_pct = stall_pct;
		write_reg(CFG_GATE_THRESHOLD, thr);
		write_reg(CFG_MIN_LOUD_CHUNKS, CFG_DATA_W'(min_run));
		@(negedge clk);
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		start_phase(0, 0, 16'd100, 8'd2);
		push_word(REQ_UTTERANCE, 16'h7FFF, 1'b1);
		push_word(REQ_SAMPLE, 16'h0000, 1'b1);
		push_word(REQ_SAMPLE, 16'h7FFF, 1'b0);
		push_word(REQ_SAMPLE, 16'h8000, 1'b1);
		push_word(REQ_SAMPLE, 16'h8000, 1'b1);
		push_word(REQ_SAMPLE, 16'h7FFF, 1'b1);
		push_word(REQ_SAMPLE, 16'h8000, 1'b0);
		push_word(REQ_UTTERANCE, 16'h8000, 1'b0);
		push_word(REQ_SAMPLE, 16'hFFFF, 1'b0);
		push_word(REQ_SAMPLE, 16'h0001, 1'b0);
		push_word(REQ_SAMPLE, 16'd100, 1'b1);
		// A mean of exactly threshold+1 is loud; a mean equal to the threshold is quiet.
		push_word(REQ_SAMPLE, 16'd101, 1'b1);
		push_word(REQ_SAMPLE, 16'd100, 1'b1);
		push_word(REQ_UTTERANCE, 16'h0000, 1'b1);

		// A threshold beyond the sample range can never be met.
		start_phase(0, 0, 16'hFFFF, 8'd0);
		push_word(REQ_SAMPLE, 16'h8000, 1'b1);
		// A zero minimum latches on the first loud chunk.
		start_phase(0, 0, 16'h0000, 8'd0);
		push_word(REQ_SAMPLE, 16'h0000, 1'b1);
		push_word(REQ_SAMPLE, 16'h0001, 1'b1);
		push_word(REQ_UTTERANCE, 16'h5555, 1'b0);
		push_word(REQ_SAMPLE, 16'hAAAA, 1'b1);

		start_phase(0, 0, 16'd600, 8'd8);
		fill_random(50);
		start_phase(84, 0, THR_W'($urandom_range(2000, 0)), 8'd3);
		fill_random(50);
		start_phase(0, 84, THR_W'($urandom_range(5000, 200)), 8'd1);
		fill_random(50);
		start_phase(15, 15, 16'd32767, 8'd4);
		fill_random(50);

		// Hold the result side off while words keep coming so the input backs up.
		start_phase(0, 0, 16'd50, 8'd5);
		hold_kick = ~hold_kick;
		fill_random(40);

		// One chunk right at the sample bound and one just past it.
		start_phase(15, 15, 16'd1000, 8'd2);
		push_word(REQ_UTTERANCE, 16'h0000, 1'b0);
		push_chunk(MAX_CHUNK_SAMPLES, LVL_LOUD);
		push_chunk(MAX_CHUNK_SAMPLES + 1, LVL_MIXED);

		// Run the loud count up to its ceiling.
		start_phase(15, 15, 16'd10, 8'd255);
		push_word(REQ_UTTERANCE, 16'h0000, 1'b0);
		repeat (256)
			push_chunk(1, LVL_LOUD);
		push_chunk(2, LVL_ANY);

		start_phase(0, 84, 16'd32768, 8'd1);
		write_reg(CFG_UNUSED_INDEX, 16'hFFFF);
		@(negedge clk);
		fill_random(20);

		settle();
		repeat (8) @(negedge clk);
		if (mismatch_count == 0 && verdicts_q.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
